// ===== hdl/vlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// vlpf_pkg: shared types and constants of the varint length-prefixed framer
// Result codes, field widths and the result record passed front to back.
// ----------------------------------------------------------------------------
package vlpf_pkg;

    localparam int LEN_W      = 21;
    localparam int BYTE_W     = 8;
    localparam int ACC_W      = 32;
    localparam int DATA_BITS  = 7;
    localparam int MAX_VARINT = 5;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 21'h1F_FFFF;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TOO_LONG  = 2'd1,
        ERR_SHORT_LEN = 2'd2,
        ERR_OVER_MAX  = 2'd3
    } t_err;

    typedef struct packed {
        t_kind             kind;
        logic [LEN_W-1:0]  packet_length;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
        t_err              error_code;
    } t_result;

endpackage

// ===== hdl/varint_length_prefixed_framer.sv =====
// ----------------------------------------------------------------------------
// varint_length_prefixed_framer: one stream byte in per cycle while the queue has space, results out
// A result is registered into the result queue as its byte is accepted and reaches the output behind older entries.
// Throughput: one byte per cycle while the two-entry result queue has space; a full queue stalls the input.
// Reset (synchronous, active low): length prefix expected, queue empty, limit 2097151.
// ----------------------------------------------------------------------------
module varint_length_prefixed_framer
    import vlpf_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [LEN_W-1:0]  o_packet_length,
    output logic [BYTE_W-1:0] o_frame_id,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_last,
    output logic [1:0]        o_error_code
);

    logic    w_space;
    logic    w_push;
    t_result w_front_res;
    t_result w_out_res;

    assign o_ready = w_space;

    // decode bytes into result items
    vlpf_front #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_space    (w_space),
        .o_push     (w_push),
        .o_result   (w_front_res)
    );

    // queue results toward the output
    vlpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_result(w_front_res),
        .o_space (w_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(w_out_res)
    );

    assign o_kind          = w_out_res.kind;
    assign o_packet_length = w_out_res.packet_length;
    assign o_frame_id      = w_out_res.frame_id;
    assign o_payload_byte  = w_out_res.payload_byte;
    assign o_last          = w_out_res.last;
    assign o_error_code    = w_out_res.error_code;

endmodule

// ===== hdl/vlpf_front.sv =====
// ----------------------------------------------------------------------------
// vlpf_front: byte classifier and varint decoder
// Takes one stream byte per cycle while the queue has space, tracks the packet phase and builds at
// most one result record per byte for the queue.
// ----------------------------------------------------------------------------
module vlpf_front
    import vlpf_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_space,
    output logic              o_push,
    output t_result           o_result
);

    localparam int SW = $clog2(MAX_VARINT_BYTES + 1);

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_ID      = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [SW-1:0]    r_shift, n_shift;
    logic [ACC_W-1:0] r_accum, n_accum;
    logic [LEN_W-1:0] r_held, n_held;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic [LEN_W-1:0] r_max_len;

    logic             w_accept;
    logic [ACC_W-1:0] w_shifted;
    logic [ACC_W-1:0] w_acc_new;
    logic [SW-1:0]    w_shift_new;
    logic [LEN_W-1:0] w_id_count;
    logic [LEN_W-1:0] w_rest;

    assign w_accept    = i_valid && i_space;
    assign w_acc_new   = r_accum | w_shifted;
    assign w_shift_new = r_shift + SW'(1);
    assign w_id_count  = LEN_W'(w_shift_new);
    assign w_rest      = r_held - w_id_count;

    // place the seven data bits at the current group; bits past 31 drop
    always_comb begin
        w_shifted = '0;
        for (int k = 0; k < MAX_VARINT_BYTES; k++) begin
            if (r_shift == SW'(k) && (DATA_BITS * k) < ACC_W) begin
                w_shifted = ACC_W'({{(ACC_W-DATA_BITS){1'b0}},
                                    i_in_byte[DATA_BITS-1:0]} << (DATA_BITS * k));
            end
        end
    end

    // decode one byte
    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_accum  = r_accum;
        n_held   = r_held;
        n_remain = r_remain;
        o_push   = 1'b0;
        o_result = '{kind: KIND_HEADER, packet_length: '0, frame_id: '0,
                     payload_byte: '0, last: 1'b0, error_code: ERR_NONE};
        if (w_accept) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    o_push                = 1'b1;
                    o_result.kind         = KIND_PAYLOAD;
                    o_result.payload_byte = i_in_byte;
                    o_result.last         = (r_remain <= LEN_W'(1));
                    if (r_remain <= LEN_W'(1)) begin
                        n_remain = '0;
                        n_phase  = PH_LENGTH;
                        n_shift  = '0;
                        n_accum  = '0;
                    end else begin
                        n_remain = r_remain - LEN_W'(1);
                    end
                end
                default: begin
                    if (r_shift >= SW'(MAX_VARINT_BYTES)) begin
                        // overlong varint: drop it and restart at the length
                        o_push              = 1'b1;
                        o_result.kind       = KIND_ERROR;
                        o_result.error_code = ERR_TOO_LONG;
                        n_phase             = PH_LENGTH;
                        n_shift             = '0;
                        n_accum             = '0;
                    end else if (i_in_byte[BYTE_W-1]) begin
                        n_accum = w_acc_new;
                        n_shift = w_shift_new;
                    end else if (r_phase == PH_ID) begin
                        n_shift = '0;
                        n_accum = '0;
                        o_push  = 1'b1;
                        if (r_held < w_id_count) begin
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_SHORT_LEN;
                            n_phase             = PH_LENGTH;
                        end else begin
                            o_result.kind          = KIND_HEADER;
                            o_result.packet_length = r_held;
                            o_result.frame_id      = w_acc_new[BYTE_W-1:0];
                            o_result.last          = (w_rest == '0);
                            n_remain               = w_rest;
                            n_phase = (w_rest == '0) ? PH_LENGTH : PH_PAYLOAD;
                        end
                    end else begin
                        // length prefix complete
                        n_shift = '0;
                        n_accum = '0;
                        if (w_acc_new > ACC_W'(r_max_len)) begin
                            o_push              = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_OVER_MAX;
                            n_phase             = PH_LENGTH;
                        end else begin
                            n_held  = w_acc_new[LEN_W-1:0];
                            n_phase = PH_ID;
                        end
                    end
                end
            endcase
        end
    end

    // hold decoder state and the length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LENGTH;
            r_shift   <= '0;
            r_accum   <= '0;
            r_held    <= '0;
            r_remain  <= '0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_accum  <= n_accum;
            r_held   <= n_held;
            r_remain <= n_remain;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== hdl/vlpf_queue.sv =====
// ----------------------------------------------------------------------------
// vlpf_queue: result queue between decoder and output
// Two-entry register queue; the head entry drives the output channel.
// ----------------------------------------------------------------------------
module vlpf_queue
    import vlpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_count;
    logic            w_pop;

    assign o_space  = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rp];
    assign w_pop    = o_valid && i_ready;

    // store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_result;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sim/vlpf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpf_checker: result checker for the varint length-prefixed framer
// Watches both item channels and the register port. It predicts the framer
// result of every accepted input byte and compares each accepted output item
// field by field against the oldest prediction still due.
// ----------------------------------------------------------------------------
module vlpf_checker
    import vlpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_kind,
    input  logic [LEN_W-1:0]  i_packet_length,
    input  logic [BYTE_W-1:0] i_frame_id,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic              i_last,
    input  logic [1:0]        i_error_code,
    output int                o_fail_count,
    output int                o_pending
);

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_ID      = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // Mirror of the framer state
    logic [LEN_W-1:0] max_len;
    t_phase           ph;
    logic [2:0]       vbytes;
    logic [ACC_W-1:0] vacc;
    logic [LEN_W-1:0] held_len;
    logic [2:0]       id_bytes;
    logic [LEN_W-1:0] pay_left;

    t_result results_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    task automatic restart_prefix();
        ph     = PH_LENGTH;
        vbytes = '0;
        vacc   = '0;
    endtask

    // Predict what one accepted stream byte makes the framer emit
    task automatic frame_byte(input logic [7:0] b, output bit emitted,
                              output t_result res);
        logic [63:0] wide;
        logic        fin;
        emitted = 1'b0;
        res     = '0;

        // Pass payload through, flag the final byte of the packet
        if (ph == PH_PAYLOAD) begin
            fin              = (pay_left <= 1);
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
            res.last         = fin;
            emitted          = 1'b1;
            if (fin) begin
                pay_left = '0;
                restart_prefix();
            end else begin
                pay_left = pay_left - 1'b1;
            end
            return;
        end

        if (ph != PH_ID) ph = PH_LENGTH;

        // One byte past the varint limit is an error, whatever bit 7 says
        if (vbytes >= MAX_VARINT) begin
            restart_prefix();
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
            emitted        = 1'b1;
            return;
        end

        // Accumulate seven data bits, drop anything above bit 31
        wide   = 64'(b[6:0]) << (7 * vbytes);
        vacc   = vacc | wide[ACC_W-1:0];
        vbytes = vbytes + 1'b1;
        if (b[7]) return;

        // Length prefix done: check against the limit, then go for the id
        if (ph == PH_LENGTH) begin
            if (vacc > {{(ACC_W-LEN_W){1'b0}}, max_len}) begin
                restart_prefix();
                res.kind       = KIND_ERROR;
                res.error_code = ERR_OVER_MAX;
                emitted        = 1'b1;
                return;
            end
            held_len = vacc[LEN_W-1:0];
            ph       = PH_ID;
            vbytes   = '0;
            vacc     = '0;
            return;
        end

        // Id done: the length must cover the id bytes
        id_bytes = vbytes;
        if (held_len < LEN_W'(id_bytes)) begin
            restart_prefix();
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SHORT_LEN;
            emitted        = 1'b1;
            return;
        end
        pay_left          = held_len - LEN_W'(id_bytes);
        res.kind          = KIND_HEADER;
        res.packet_length = held_len;
        res.frame_id      = vacc[BYTE_W-1:0];
        res.last          = (pay_left == 0);
        emitted           = 1'b1;
        if (pay_left == 0) begin
            restart_prefix();
        end else begin
            ph     = PH_PAYLOAD;
            vbytes = '0;
            vacc   = '0;
        end
    endtask

    // Compare output items first: they stem from bytes of earlier edges
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        bit      emitted;
        if (!i_rst_n) begin
            max_len  = MAX_LEN_RESET;
            restart_prefix();
            held_len = '0;
            id_bytes = '0;
            pay_left = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) max_len = i_cfg_wdata;

            if (i_out_valid && i_out_ready) begin
                got = t_result'({i_kind, i_packet_length, i_frame_id,
                                 i_payload_byte, i_last, i_error_code});
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected item kind %0d", i_kind));
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("packet_length", 32'(got.packet_length),
                                32'(want.packet_length));
                    check_field("frame_id", 32'(got.frame_id), 32'(want.frame_id));
                    check_field("payload_byte", 32'(got.payload_byte),
                                32'(want.payload_byte));
                    check_field("last", 32'(got.last), 32'(want.last));
                    check_field("error_code", 32'(got.error_code),
                                32'(want.error_code));
                end
            end

            if (i_in_valid && i_in_ready) begin
                frame_byte(i_in_byte, emitted, predicted);
                if (emitted) results_due.push_back(predicted);
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench of the varint length-prefixed framer
// Drives a byte stream of directed then random packets, good and broken,
// under several length limits with random gaps on both channels. The checker
// beside the framer predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import vlpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_ITEMS    = 40;
    localparam int PHASE_ITEMS    = 310;
    localparam int N_PHASES       = 6;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [LEN_W-1:0]  i_cfg_wdata;
    logic              i_valid;
    logic              o_ready;
    logic [BYTE_W-1:0] i_in_byte;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_kind;
    logic [LEN_W-1:0]  o_packet_length;
    logic [BYTE_W-1:0] o_frame_id;
    logic [BYTE_W-1:0] o_payload_byte;
    logic              o_last;
    logic [1:0]        o_error_code;

    int          fails;
    int          pend;
    int          n_sent;
    int          stall_cycles;
    int unsigned cur_max;
    bit          calm;
    bit          hold_req;

    varint_length_prefixed_framer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_packet_length (o_packet_length),
        .o_frame_id      (o_frame_id),
        .o_payload_byte  (o_payload_byte),
        .o_last          (o_last),
        .o_error_code    (o_error_code)
    );

    vlpf_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_kind          (o_kind),
        .i_packet_length (o_packet_length),
        .i_frame_id      (o_frame_id),
        .i_payload_byte  (o_payload_byte),
        .i_last          (o_last),
        .i_error_code    (o_error_code),
        .o_fail_count    (fails),
        .o_pending       (pend)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // End the run when no item moves for too long
    initial stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL varint_length_prefixed_framer");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Receiver: random stalls, a long hold on request, none while calm
    initial begin
        int len;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 30) begin
                len = gap_len();
                i_ready <= 1'b0;
                repeat (len - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the framer takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    // Encode a value as exactly n varint bytes; short values get zero padding
    task automatic send_varint(input logic [63:0] value, input int n);
        for (int i = 0; i < n; i++) begin
            send_byte({(i < n - 1), value[7*i +: 7]});
        end
    endtask

    function automatic int min_bytes(input logic [63:0] value);
        int n;
        n = 1;
        while ((value >> (7 * n)) != 0 && n < 9) n++;
        return n;
    endfunction

    function automatic int pad_bytes(input logic [63:0] value);
        int n;
        n = min_bytes(value);
        if (n < MAX_VARINT && $urandom_range(0, 9) == 0) n = $urandom_range(n, MAX_VARINT);
        return n;
    endfunction

    task automatic send_frame(input logic [63:0] len, input int len_n,
                              input logic [63:0] id, input int id_n, input int pay);
        send_varint(len, len_n);
        send_varint(id, id_n);
        repeat (pay) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Five continued bytes, then one more that overruns the varint
    task automatic send_overlong();
        repeat (MAX_VARINT) send_byte(8'h80 | 8'($urandom_range(0, 127)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_id_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 1;
        if (r < 85) return 2;
        return $urandom_range(3, MAX_VARINT);
    endfunction

    // One random sequence: mostly good packets, some broken, some noise
    task automatic send_random_frame();
        int          r;
        int          id_n;
        int unsigned pay;
        int unsigned lim;
        logic [63:0] len;
        logic [63:0] id;
        r  = $urandom_range(0, 99);
        id = {$urandom, $urandom};
        if (r < 75) begin
            id_n = pick_id_bytes();
            if (id_n > cur_max) id_n = cur_max;
            pay = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 48);
            if (pay > cur_max - id_n) pay = cur_max - id_n;
            len = id_n + pay;
            send_frame(len, pad_bytes(len), id, id_n, pay);
        end else if (r < 83) begin
            // Length over the limit, often right at the boundary
            if ($urandom_range(0, 1)) begin
                len = 64'(cur_max) + 1 + $urandom_range(0, 3);
            end else begin
                len = 64'($urandom);
                if (len <= cur_max) len = 64'(cur_max) + 1;
            end
            send_varint(len, pad_bytes(len));
        end else if (r < 88) begin
            // Length shorter than the id that follows
            id_n = $urandom_range(1, MAX_VARINT);
            lim  = (id_n - 1 < cur_max) ? id_n - 1 : cur_max;
            len  = $urandom_range(0, lim);
            send_varint(len, pad_bytes(len));
            send_varint(id, id_n);
        end else if (r < 94) begin
            if ($urandom_range(0, 1)) begin
                send_overlong();
            end else begin
                len = $urandom_range(1, (cur_max < 64) ? cur_max : 64);
                send_varint(len, min_bytes(len));
                send_overlong();
            end
        end else if (cur_max <= 255) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_overlong();
        end
    endtask

    // Drop valid and wait until every predicted item has come out
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pend != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max(input logic [LEN_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        cur_max      = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        int target;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_in_byte   = '0;
        n_sent      = 0;
        cur_max     = MAX_LEN_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty packet, byte extremes, two-byte id
        send_frame(1, 1, 0, 1, 0);
        send_varint(3, 1);
        send_varint(64'h7F, 1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(2, 1, 64'h1234, 2, 0);
        // Zero length against a one-byte id
        send_frame(0, 1, 5, 1, 0);
        // Overlong prefix whose sixth byte has bit 7 clear
        send_varint(64'h0, MAX_VARINT + 1);
        // Data bits above bit 31 drop out, leaving a length of one
        send_frame(64'h7_0000_0001, MAX_VARINT, 0, 1, 0);
        // Lengths over the reset limit, one of them the 32-bit maximum
        send_varint(64'h20_0000, 4);
        send_varint(64'hFFFF_FFFF, MAX_VARINT);
        // Overlong id, then a five-byte id with its top bits set
        send_varint(2, 1);
        send_overlong();
        send_frame(6, 1, 64'h7_FFFF_FFFF, MAX_VARINT, 1);

        // Random phases under a range of limits, the extremes among them
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1:       write_max(1);
                    2:       write_max(LEN_W'($urandom_range(2, 64)));
                    3:       write_max(MAX_LEN_RESET);
                    4:       write_max(LEN_W'($urandom_range(65, MAX_LEN_RESET - 1)));
                    default: write_max(LEN_W'($urandom_range(2, 255)));
                endcase
            end
            target = n_sent + PHASE_ITEMS;

            // Hold the receiver off while bytes keep coming
            if (p == 3) begin
                hold_req = 1'b1;
                calm     = 1'b1;
                while (n_sent < target - PHASE_ITEMS + BURST_ITEMS) send_random_frame();
                calm = 1'b0;
            end

            while (n_sent < target) begin
                if (p == 2 && n_sent >= target - PHASE_ITEMS / 2
                        && n_sent < target - PHASE_ITEMS / 2 + 8) begin
                    settle();
                end
                if ($urandom_range(0, 29) == 0) calm = !calm;
                send_random_frame();
            end
        end

        // Drain and give the verdict
        @(negedge i_clk);
        i_valid <= 1'b0;
        calm = 1'b0;
        while (pend != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fails == 0 && pend == 0) begin
            $display("PASS varint_length_prefixed_framer");
        end else begin
            $display("FAIL varint_length_prefixed_framer");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/vlpf_pkg.sv
hdl/vlpf_front.sv
hdl/vlpf_queue.sv
hdl/varint_length_prefixed_framer.sv
sim/vlpf_checker.sv
sim/tb.sv
